FILE: src/wpve_pkg.sv
// Shared types and constants for the windowed position velocity estimator.
package wpve_pkg;
  localparam int unsigned AXES = 3;
  localparam logic [31:0] WINDOW_LENGTH_RST = 32'd15000;
  localparam logic [31:0] MIN_INTERVAL_RST = 32'd100;
  localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [0:0] REG_MIN_INTERVAL = 1'b1;
  localparam int unsigned NUM_W = 49;
  localparam int unsigned QUOT_W = 49;

  typedef struct packed {
    logic [31:0] time_stamp;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic accepted;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } out_word_t;

  typedef struct packed {
    logic [7:0] index;
    logic [31:0] data;
  } cfg_word_t;

  typedef struct packed {
    logic start;
    logic [31:0] elapsed;
  } div_ctl_t;
endpackage

FILE: src/wpve_if.sv
// Valid/ready channel interface carrying one word of payload type.
interface wpve_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/wpve_div_lane.sv
// One axis lane: position difference scaled by 2^16, divided bit-serially, saturated.
module wpve_div_lane import wpve_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  div_ctl_t           ctl,
  input  logic signed [31:0] now_pos,
  input  logic signed [31:0] then_pos,
  output logic               done,
  output logic signed [31:0] quot
);
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic neg_r;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic signed [32:0] diff;
  logic [32:0] mag;
  logic [33:0] trial;

  assign diff = 33'(now_pos) - 33'(then_pos);
  assign mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign trial = {rem_r, num_r[NUM_W-1]} - {2'b0, den_r};

  always_comb begin
    rem_nxt = rem_r;
    num_nxt = num_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (ctl.start) begin
      rem_nxt = '0;
      num_nxt = {mag, 16'd0};
      cnt_nxt = 6'(QUOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        num_nxt = {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], num_r[NUM_W-1]};
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    if (ctl.start) begin
      den_r <= ctl.elapsed;
      neg_r <= diff[32];
    end
  end

  assign done = busy_r && (cnt_r == 6'd1);

  // num_nxt holds the final quotient magnitude on the last step
  always_comb begin
    if (neg_r) begin
      if (num_nxt > {{(QUOT_W-32){1'b0}}, 32'h8000_0000}) quot = 32'sh8000_0000;
      else quot = -$signed(num_nxt[31:0]);
    end else begin
      if (num_nxt > {{(QUOT_W-32){1'b0}}, 32'h7FFF_FFFF}) quot = 32'sh7FFF_FFFF;
      else quot = $signed(num_nxt[31:0]);
    end
  end
endmodule

FILE: src/windowed_position_velocity_estimator.sv
// Top level of the windowed position velocity estimator.
// A dropped word goes from the check straight to the output. A stored word is checked, written,
// then a read and a compare per window entry (up to 16 entries at the default HISTORY_DEPTH),
// then divided bit-serially in three axis lanes unless the elapsed time is zero.
// Words are handled one at a time; one result may wait at the output.
// Synchronous reset (rst_n) restores the register defaults and makes all history read as zero.
module windowed_position_velocity_estimator import wpve_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input logic clk,
  input logic rst_n,
  wpve_if.sink   in_ch,
  wpve_if.source out_ch,
  wpve_if.sink   cfg_ch
);
  localparam int unsigned IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [IW-1:0] LAST = IW'(HISTORY_DEPTH - 1);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_WRITE, S_READ, S_WALK, S_DIV, S_OUT} state_t;
  state_t state_r;

  // History as memories with one registered read port; valid bits stand in for reset.
  logic [31:0] mem_t [HISTORY_DEPTH];
  logic [31:0] mem_x [HISTORY_DEPTH];
  logic [31:0] mem_y [HISTORY_DEPTH];
  logic [31:0] mem_z [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] vld_r;
  logic [IW-1:0] rd_addr;
  logic [31:0] rd_t_r, rd_x_r, rd_y_r, rd_z_r;
  logic rd_vld_r;
  logic [31:0] rt;

  logic [31:0] win_len_r, min_int_r;
  logic [IW-1:0] newest_r, window_r;
  logic [IW-1:0] steps_r;
  logic [31:0] elapsed_r;
  in_word_t cur_r;
  logic acc_r;
  logic signed [31:0] vel_r [AXES];
  out_word_t out_r;
  logic out_v_r;
  logic out_load;
  logic [IW-1:0] nxt_idx;
  div_ctl_t dctl;
  logic [AXES-1:0] ldone;
  logic signed [31:0] lq [AXES];
  logic signed [31:0] lnow [AXES];
  logic signed [31:0] lthen [AXES];
  logic [31:0] el;

  assign nxt_idx = (newest_r == LAST) ? '0 : newest_r + IW'(1);
  assign rt = rd_vld_r ? rd_t_r : 32'd0;
  assign el = cur_r.time_stamp - rt;

  // The output register may still hold an unread word while the next one is worked on;
  // a finished result is loaded once that register is empty or being read.
  assign out_load = (state_r == S_OUT) && (!out_v_r || out_ch.ready);

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v_r;
  assign out_ch.data = out_r;

  always_comb begin
    unique case (state_r)
      S_IDLE: rd_addr = newest_r;
      default: rd_addr = window_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_t_r <= mem_t[rd_addr];
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
    rd_z_r <= mem_z[rd_addr];
    if (state_r == S_WRITE) begin
      mem_t[newest_r] <= cur_r.time_stamp;
      mem_x[newest_r] <= cur_r.pos_x;
      mem_y[newest_r] <= cur_r.pos_y;
      mem_z[newest_r] <= cur_r.pos_z;
    end
  end

  assign dctl.start = (state_r == S_WALK) && !((el >= win_len_r) && (steps_r != LAST))
                      && (el != 32'd0);
  assign dctl.elapsed = el;
  assign lnow[0] = cur_r.pos_x;
  assign lnow[1] = cur_r.pos_y;
  assign lnow[2] = cur_r.pos_z;
  assign lthen[0] = rd_vld_r ? $signed(rd_x_r) : 32'sd0;
  assign lthen[1] = rd_vld_r ? $signed(rd_y_r) : 32'sd0;
  assign lthen[2] = rd_vld_r ? $signed(rd_z_r) : 32'sd0;

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    wpve_div_lane u_lane (
      .clk(clk), .rst_n(rst_n), .ctl(dctl),
      .now_pos(lnow[a]), .then_pos(lthen[a]),
      .done(ldone[a]), .quot(lq[a])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r <= '0;
      rd_vld_r <= 1'b0;
      win_len_r <= WINDOW_LENGTH_RST;
      min_int_r <= MIN_INTERVAL_RST;
      newest_r <= '0;
      window_r <= LAST;
      out_v_r <= 1'b0;
      for (int i = 0; i < AXES; i++) vel_r[i] <= '0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (cfg_ch.valid) begin
        if (cfg_ch.data.index == 8'(REG_WINDOW_LENGTH)) win_len_r <= cfg_ch.data.data;
        else if (cfg_ch.data.index == 8'(REG_MIN_INTERVAL)) min_int_r <= cfg_ch.data.data;
      end
      if (out_load) out_v_r <= 1'b1;
      else if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            cur_r <= in_ch.data;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (el >= min_int_r) begin
            newest_r <= nxt_idx;
            acc_r <= 1'b1;
            state_r <= S_WRITE;
          end else begin
            acc_r <= 1'b0;
            state_r <= S_OUT;
          end
        end
        S_WRITE: begin
          vld_r[newest_r] <= 1'b1;
          steps_r <= '0;
          state_r <= S_READ;
        end
        S_READ: begin
          // The window entry is read here, after the new sample has been written,
          // so a window that has caught up with the newest entry sees its data.
          state_r <= S_WALK;
        end
        S_WALK: begin
          // rd_* holds the entry at window_r, read in the previous cycle
          if ((el >= win_len_r) && (steps_r != LAST)) begin
            window_r <= (window_r == LAST) ? '0 : window_r + IW'(1);
            steps_r <= steps_r + IW'(1);
            state_r <= S_READ;
          end else if (el != 32'd0) begin
            state_r <= S_DIV;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          if (ldone[0]) begin
            for (int i = 0; i < AXES; i++) vel_r[i] <= lq[i];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_r.accepted <= acc_r;
            out_r.vel_x <= vel_r[0];
            out_r.vel_y <= vel_r[1];
            out_r.vel_z <= vel_r[2];
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The three lanes start together and take the same number of steps.
  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    ldone[0] |-> (ldone[1] && ldone[2]))
    else $error("division lanes out of step");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> out_v_r)
    else $error("pending result lost");
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready)
    else $error("input taken while busy");
endmodule
